// ===== hw/rtl/ioc_pkg.sv =====
package ioc_pkg;

  // Text and histogram dimensions
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned ALPHABET_BINS  = 26;
  localparam int unsigned BIN_W          = $clog2(ALPHABET_BINS);
  localparam int unsigned LETTER_W       = 16;
  localparam int unsigned PAIR_W         = 2 * LETTER_W;
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned QUO_W          = FRAC_BITS + 1;

  // ASCII letter bounds
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;

  // Per-cell control: count one letter, or take the neighbour's count
  typedef struct packed {
    logic inc;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/ioc_cell.sv =====
module ioc_cell #(
  parameter int unsigned CNT_W = ioc_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ioc_pkg::cell_ctrl_t ctrl,
  input  logic [CNT_W-1:0]    upstream,
  output logic [CNT_W-1:0]    count
);

  // Hold one bin count; shift towards the head of the chain while draining
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.shift) begin
      count <= upstream;
    end else if (ctrl.inc) begin
      count <= count + CNT_W'(1);
    end
  end

endmodule

// ===== hw/rtl/ioc_divider.sv =====
module ioc_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [ioc_pkg::PAIR_W-1:0]       dividend,
  input  logic [ioc_pkg::PAIR_W-1:0]       divisor,
  output logic                             done,
  output logic [ioc_pkg::QUO_W-1:0]        quotient
);

  localparam int unsigned REM_W  = ioc_pkg::PAIR_W + 1;
  localparam int unsigned STEP_W = $clog2(ioc_pkg::QUO_W + 1);

  logic [REM_W-1:0]          rem;
  logic [ioc_pkg::PAIR_W-1:0] den;
  logic [STEP_W-1:0]         steps;
  logic                      busy;
  logic                      fits;
  logic [REM_W-1:0]          rem_sub;

  // One restoring step: compare, subtract when the divisor fits
  assign fits    = rem >= {1'b0, den};
  assign rem_sub = fits ? (rem - {1'b0, den}) : rem;

  // Produce one quotient bit per cycle, most significant first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(ioc_pkg::QUO_W);
        rem   <= {1'b0, dividend};
        den   <= divisor;
      end else if (busy) begin
        quotient <= {quotient[ioc_pkg::QUO_W-2:0], fits};
        rem      <= {rem_sub[REM_W-2:0], 1'b0};
        steps    <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/index_of_coincidence_unit.sv =====
// Letters are counted at one byte per cycle while the input is not stalled.
// After the last byte the 26-cell chain drains through one multiplier, then
// N*(N-1) is formed and the result is loaded; for a last byte with two or more
// letters the divider start, load and 17 shift-subtract steps follow before
// the result is valid, while with fewer than two letters the divider is skipped.
// Input stalls meanwhile, and while an earlier result still waits.
// Reset (rst, synchronous) clears the bins, letter total, overflow flag and handshakes.
module index_of_coincidence_unit #(
  parameter int unsigned COUNT_BITS = ioc_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              char_valid,
  output logic                              char_stall,
  input  logic [7:0]                        char_byte,
  input  logic                              last_byte,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [ioc_pkg::PAIR_W-1:0]        pair_sum,
  output logic [ioc_pkg::PAIR_W-1:0]        pair_total,
  output logic [ioc_pkg::QUO_W-1:0]         coincidence_fraction,
  output logic [ioc_pkg::LETTER_W-1:0]      letter_total,
  output logic                              too_few_letters,
  output logic                              count_overflow
);

  localparam int unsigned CNT_W = (COUNT_BITS >= ioc_pkg::LETTER_W) ?
                                  ioc_pkg::LETTER_W : COUNT_BITS;
  localparam logic [ioc_pkg::LETTER_W-1:0] COUNT_MAX =
      ioc_pkg::LETTER_W'((64'd1 << CNT_W) - 64'd1);
  localparam int unsigned BINS = ioc_pkg::ALPHABET_BINS;

  typedef enum logic [2:0] {
    S_COUNT,
    S_DRAIN,
    S_TOTAL,
    S_LOAD,
    S_DIV
  } state_t;

  state_t                          state;
  logic [ioc_pkg::LETTER_W-1:0]    letters_seen;
  logic                            overflow_seen;
  logic [ioc_pkg::BIN_W-1:0]       drain_idx;
  logic [ioc_pkg::PAIR_W-1:0]      acc;
  logic [ioc_pkg::PAIR_W-1:0]      prod;
  logic                            div_start;
  logic                            div_done;
  logic [ioc_pkg::QUO_W-1:0]       div_quotient;

  logic [CNT_W-1:0]                counts [BINS];
  logic                            is_upper;
  logic                            is_lower;
  logic                            is_letter;
  logic [ioc_pkg::BIN_W-1:0]       bin;
  logic                            sat;
  logic                            count_fire;
  logic                            few;
  logic [ioc_pkg::LETTER_W-1:0]    mul_a;
  logic [ioc_pkg::LETTER_W-1:0]    mul_b;

  // Classify the byte and fold case into one bin
  assign is_upper  = (char_byte >= ioc_pkg::ASCII_UPPER_A) &&
                     (char_byte <= ioc_pkg::ASCII_UPPER_Z);
  assign is_lower  = (char_byte >= ioc_pkg::ASCII_LOWER_A) &&
                     (char_byte <= ioc_pkg::ASCII_LOWER_Z);
  assign is_letter = is_upper || is_lower;
  assign bin       = is_upper ? ioc_pkg::BIN_W'(char_byte - ioc_pkg::ASCII_UPPER_A)
                              : ioc_pkg::BIN_W'(char_byte - ioc_pkg::ASCII_LOWER_A);
  assign sat        = letters_seen >= COUNT_MAX;
  assign char_stall = (state != S_COUNT);
  assign count_fire = (state == S_COUNT) && char_valid && is_letter && !sat;
  assign few        = letters_seen < ioc_pkg::LETTER_W'(2);

  // Chain of bin cells; the tail takes zero so the drain clears the histogram
  for (genvar i = 0; i < BINS; i++) begin : g_cell
    ioc_pkg::cell_ctrl_t ctrl;
    logic [CNT_W-1:0]    upstream;

    assign ctrl.inc   = count_fire && (bin == ioc_pkg::BIN_W'(i));
    assign ctrl.shift = (state == S_DRAIN);

    if (i == BINS - 1) begin : g_tail
      assign upstream = '0;
    end else begin : g_link
      assign upstream = counts[i+1];
    end

    ioc_cell #(
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .upstream (upstream),
      .count    (counts[i])
    );
  end

  // Shared multiplier operands: head bin while draining, letter total after
  assign mul_a = (state == S_DRAIN) ? ioc_pkg::LETTER_W'(counts[0]) : letters_seen;
  assign mul_b = mul_a - ioc_pkg::LETTER_W'(1);

  ioc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (prod),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Sequence counting, drain, pair total, divide and result hand-off
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_COUNT;
      letters_seen  <= '0;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
      drain_idx     <= '0;
      div_start     <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_COUNT: begin
          if (char_valid) begin
            if (is_letter) begin
              if (sat) begin
                overflow_seen <= 1'b1;
              end else begin
                letters_seen <= letters_seen + ioc_pkg::LETTER_W'(1);
              end
            end
            if (last_byte) begin
              state     <= S_DRAIN;
              drain_idx <= '0;
              acc       <= '0;
              prod      <= '0;
            end
          end
        end
        S_DRAIN: begin
          acc       <= acc + prod;
          prod      <= mul_a * mul_b;
          drain_idx <= drain_idx + ioc_pkg::BIN_W'(1);
          if (drain_idx == ioc_pkg::BIN_W'(BINS - 1)) begin
            state <= S_TOTAL;
          end
        end
        S_TOTAL: begin
          acc   <= acc + prod;
          prod  <= mul_a * mul_b;
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (!result_valid || !result_stall) begin
            pair_sum        <= acc;
            pair_total      <= prod;
            letter_total    <= letters_seen;
            too_few_letters <= few;
            count_overflow  <= overflow_seen;
            letters_seen    <= '0;
            overflow_seen   <= 1'b0;
            if (few) begin
              coincidence_fraction <= '0;
              result_valid         <= 1'b1;
              state                <= S_COUNT;
            end else begin
              div_start <= 1'b1;
              state     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            coincidence_fraction <= div_quotient;
            result_valid         <= 1'b1;
            state                <= S_COUNT;
          end
        end
        default: begin
          state <= S_COUNT;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/ioc_checker.sv =====
module ioc_assertions (
  input logic                              clk,
  input logic                              rst,
  input logic                              char_valid,
  input logic                              char_stall,
  input logic                              last_byte,
  input logic                              result_valid,
  input logic                              result_stall,
  input logic [ioc_pkg::PAIR_W-1:0]        pair_sum,
  input logic [ioc_pkg::PAIR_W-1:0]        pair_total,
  input logic [ioc_pkg::QUO_W-1:0]         coincidence_fraction,
  input logic [ioc_pkg::LETTER_W-1:0]      letter_total,
  input logic                              too_few_letters
);

  // A held result keeps its payload until the transfer
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(pair_sum) && $stable(coincidence_fraction))
    else $error("result payload changed while stalled");

  // Pair sum never exceeds the pair total
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pair_sum <= pair_total)
    else $error("pair_sum above pair_total");

  // Short texts give zero totals and a zero fraction
  a_few: assert property (@(posedge clk) disable iff (rst)
    result_valid && too_few_letters |->
      coincidence_fraction == '0 && pair_total == '0 && pair_sum == '0)
    else $error("short text result not zero");

  // The flag agrees with the letter total and the fraction stays in range
  a_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (too_few_letters == (letter_total < ioc_pkg::LETTER_W'(2))) &&
      coincidence_fraction <= ioc_pkg::QUO_W'(1 << ioc_pkg::FRAC_BITS))
    else $error("flag or fraction inconsistent");

  // The last byte starts the drain, so the input stalls next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall && last_byte |=> char_stall)
    else $error("input not stalled after last byte");

endmodule

bind index_of_coincidence_unit ioc_assertions u_ioc_assertions (
  .clk                  (clk),
  .rst                  (rst),
  .char_valid           (char_valid),
  .char_stall           (char_stall),
  .last_byte            (last_byte),
  .result_valid         (result_valid),
  .result_stall         (result_stall),
  .pair_sum             (pair_sum),
  .pair_total           (pair_total),
  .coincidence_fraction (coincidence_fraction),
  .letter_total         (letter_total),
  .too_few_letters      (too_few_letters)
);
